// ----- hw/rtl/rsk_pkg.sv -----
package rsk_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_W       = 10;
  localparam int TAG_W       = 8;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             end_of_set;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // what a cell shows its right-hand neighbor
  typedef struct packed {
    logic take;
    rec_t rec;
  } cell_st_t;

  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ----- hw/rtl/record_sort_by_key.sv -----
// Stable ascending sort of a set of {key, tag} records.
// Input channel in_valid/in_ready/in_data: one record per beat, at most one
// beat per cycle; the beat with last set closes the set. Up to MAX_RECORDS
// records are held; further records of the same set are dropped, though a
// dropped record with last still closes the set.
// Each record is placed in a chain of MAX_RECORDS insertion cells in the
// cycle it is accepted, so filling runs at one record per cycle.
// After the closing beat in_ready drops and, in the same cycle, the chain
// drains through out_valid/out_ready/out_data, one record per cycle while
// out_ready is high, in ascending key order, equal keys in arrival order;
// end_of_set marks the last one.
// A stalled receiver holds the chain: out_data stays put until taken.
// in_ready returns the cycle after the final beat is taken.
// Reset (rst_n low, synchronous) empties the chain and readies the input.
module record_sort_by_key (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsk_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsk_pkg::out_t out_data
);
  import rsk_pkg::*;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cell_ctl_t        ctl;
  cell_st_t         cst [MAX_RECORDS];
  logic             in_acc;
  logic             out_acc;
  logic             last_out;

  assign in_ready  = (st_r == ST_FILL);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (st_r == ST_DRAIN) && cst[0].rec.valid;
  assign out_acc   = out_valid && out_ready;
  assign last_out  = !cst[1].rec.valid;

  assign ctl.ins   = in_acc && (cnt_r < CNT_W'(MAX_RECORDS));
  assign ctl.shift = out_acc;
  assign ctl.key   = in_data.key;
  assign ctl.tag   = in_data.tag;

  assign out_data.sorted_key = cst[0].rec.key;
  assign out_data.sorted_tag = cst[0].rec.tag;
  assign out_data.end_of_set = last_out;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      ST_FILL: begin
        if (ctl.ins) cnt_nxt = cnt_r + CNT_W'(1);
        if (in_acc && in_data.last) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && last_out) begin
          st_nxt  = ST_FILL;
          cnt_nxt = '0;
        end
      end
      default: begin
        st_nxt  = ST_FILL;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_FILL;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    cell_st_t left;
    rec_t     right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = cst[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cst[i+1].rec;
    end
    rsk_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .st    (cst[i])
    );
  end

endmodule

// ----- hw/rtl/rsk_cell.sv -----
module rsk_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rsk_pkg::cell_ctl_t ctl,
  input  rsk_pkg::cell_st_t  left,
  input  rsk_pkg::rec_t      right,
  output rsk_pkg::cell_st_t  st
);
  import rsk_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic take;

  // first cell holding a larger key (or empty) takes the new record; later ones shift right
  assign take     = !rec_r.valid || (rec_r.key > ctl.key);
  assign st.take  = take;
  assign st.rec   = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins && take) begin
      if (left.take) begin
        rec_nxt = left.rec;
      end else begin
        rec_nxt.valid = 1'b1;
        rec_nxt.key   = ctl.key;
        rec_nxt.tag   = ctl.tag;
      end
    end else if (ctl.shift) begin
      rec_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

endmodule

// ----- hw/rtl/rsk_checker.sv -----
module rsk_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input rsk_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input rsk_pkg::out_t out_data
);
  import rsk_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results are pending");

  a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last) |=> (out_valid && !in_ready))
    else $error("closing beat not followed by results");

  a_end_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.end_of_set) |=> (in_ready && !out_valid))
    else $error("input not reopened after end of set");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind record_sort_by_key rsk_checker u_rsk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
